>>> design/cfm_pkg.sv
// Package with the shared widths, reset values and types of the capture frequency meter.
package cfm_pkg;

  localparam int unsigned NumChannels = 2;
  localparam int unsigned TimerBits   = 16;
  localparam int unsigned StampBits   = 24;
  localparam int unsigned CfgBits     = 24;
  localparam int unsigned FreqBits    = 24;
  localparam int unsigned ChanBits    = 1;
  localparam int unsigned CfgIdxBits  = 1;
  localparam int unsigned DivCntBits  = $clog2(FreqBits + 1);

  localparam logic [CfgBits-1:0] RefClockReset = CfgBits'(1000000);
  localparam logic [CfgBits-1:0] TimeoutReset  = CfgBits'(10500000);

  localparam logic [CfgIdxBits-1:0] CfgRefClock = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgTimeout  = CfgIdxBits'(1);

  localparam logic ModeCapture = 1'b0;
  localparam logic ModeQuery   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> design/capture_frequency_meter.sv
// Top level of the two-channel input capture frequency meter.
//
//   Channel  Handshake               Payload
//   input    in_valid_i/in_ready_o   mode_i, channel_i, capture_value_i, now_stamp_i
//   result   out_valid_o/out_ready_i frequency_o, valid_res_o
//   config   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A capture transaction gives no result.
// A query that needs a division waits for the bit-serial divider.
// Any other query puts its result in the output register on the next cycle.
// Reset restores the default register values and clears all channel state.
// Input is not taken while a division runs or a result waits to be taken.
module capture_frequency_meter
  import cfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [ChanBits-1:0]   channel_i,
  input  logic [TimerBits-1:0]  capture_value_i,
  input  logic [StampBits-1:0]  now_stamp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FreqBits-1:0]   frequency_o,
  output logic                  valid_res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]    cfg_data_i
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  state_e                 state_q;
  logic [CfgBits-1:0]     ref_clock_q;
  logic [CfgBits-1:0]     timeout_q;
  logic [TimerBits-1:0]   last_cap_q [NumChannels];
  logic [TimerBits-1:0]   period_q   [NumChannels];
  logic [StampBits-1:0]   edge_stamp_q [NumChannels];
  logic [NumChannels-1:0] chan_valid_q;
  logic [FreqBits-1:0]    held_freq_q;
  logic                   held_valid_q;
  logic                   out_valid_q;
  logic [FreqBits-1:0]    out_freq_q;
  logic                   out_vres_q;

  logic                   in_fire;
  logic [StampBits-1:0]   age;
  logic                   fresh;
  logic                   compute;
  logic                   div_start;
  logic                   out_load;
  div_status_t            div_status;
  logic [FreqBits-1:0]    quotient;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign age     = now_stamp_i - edge_stamp_q[channel_i];
  assign fresh   = (age < timeout_q);
  assign compute = fresh && (period_q[channel_i] != '0) && chan_valid_q[channel_i];
  assign div_start = in_fire && (mode_i == ModeQuery) && compute;
  assign out_load  = (in_fire && (mode_i == ModeQuery) && !compute) ||
                     ((state_q == ST_DIV) && div_status.done);

  cfm_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ref_clock_q),
    .divisor_i  (period_q[channel_i]),
    .status_o   (div_status),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ref_clock_q  <= RefClockReset;
      timeout_q    <= TimeoutReset;
      chan_valid_q <= '0;
      held_freq_q  <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_freq_q   <= '0;
      out_vres_q   <= 1'b0;
      for (int k = 0; k < NumChannels; k++) begin
        last_cap_q[k]   <= '0;
        period_q[k]     <= '0;
        edge_stamp_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgRefClock: ref_clock_q <= cfg_data_i;
          CfgTimeout:  timeout_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (mode_i == ModeCapture) begin
              period_q[channel_i]     <= capture_value_i - last_cap_q[channel_i];
              last_cap_q[channel_i]   <= capture_value_i;
              edge_stamp_q[channel_i] <= now_stamp_i;
              chan_valid_q[channel_i] <= 1'b1;
            end else if (compute) begin
              state_q <= ST_DIV;
            end else if (!fresh) begin
              chan_valid_q[channel_i] <= 1'b0;
              held_valid_q <= 1'b0;
              out_valid_q  <= 1'b1;
              out_freq_q   <= held_freq_q;
              out_vres_q   <= 1'b0;
            end else begin
              out_valid_q <= 1'b1;
              out_freq_q  <= held_freq_q;
              out_vres_q  <= held_valid_q;
            end
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            held_freq_q  <= quotient;
            held_valid_q <= 1'b1;
            out_valid_q  <= 1'b1;
            out_freq_q   <= quotient;
            out_vres_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign frequency_o = out_freq_q;
  assign valid_res_o = out_vres_q;

endmodule

>>> design/cfm_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module cfm_divider
  import cfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FreqBits-1:0]  dividend_i,
  input  logic [TimerBits-1:0] divisor_i,
  output div_status_t          status_o,
  output logic [FreqBits-1:0]  quotient_o
);

  logic [DivCntBits-1:0] count_q, count_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [FreqBits-1:0]   quot_q, quot_d;
  logic [TimerBits:0]    rem_q, rem_d;
  logic [TimerBits-1:0]  div_q, div_d;
  logic [TimerBits:0]    rem_shift;
  logic [TimerBits:0]    rem_sub;
  logic                  fits;

  assign rem_shift = {rem_q[TimerBits-1:0], quot_q[FreqBits-1]};
  assign rem_sub   = rem_shift - {1'b0, div_q};
  assign fits      = (rem_shift >= {1'b0, div_q});

  always_comb begin
    count_d = count_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    quot_d  = quot_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d  = 1'b1;
      count_d = DivCntBits'(FreqBits);
      quot_d  = dividend_i;
      rem_d   = '0;
      div_d   = divisor_i;
    end else if (busy_q) begin
      rem_d   = fits ? rem_sub : rem_shift;
      quot_d  = {quot_q[FreqBits-2:0], fits};
      count_d = count_q - DivCntBits'(1);
      if (count_q == DivCntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quot_q;

endmodule

>>> tb/tb_capture_frequency_meter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the capture frequency meter with its own reading predictor.
module tb_capture_frequency_meter;
  import cfm_pkg::*;

  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned PressurePhase = 7;

  typedef struct packed {
    logic                 mode;
    logic [ChanBits-1:0]  channel;
    logic [TimerBits-1:0] capture;
    logic [StampBits-1:0] stamp;
  } meter_item_t;

  typedef struct packed {
    logic [FreqBits-1:0] freq;
    logic                valid;
  } meter_reading_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic                  mode_i          = ModeCapture;
  logic [ChanBits-1:0]   channel_i       = '0;
  logic [TimerBits-1:0]  capture_value_i = '0;
  logic [StampBits-1:0]  now_stamp_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [FreqBits-1:0]   frequency_o;
  logic                  valid_res_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i     = CfgRefClock;
  logic [CfgBits-1:0]    cfg_data_i      = '0;

  meter_item_t    pending_items_q[$];
  meter_reading_t reading_q[$];

  // Predictor state of the meter.
  logic [CfgBits-1:0]   ref_hz_m  = RefClockReset;
  logic [CfgBits-1:0]   timeout_m = TimeoutReset;
  logic [TimerBits-1:0] last_cap_m   [NumChannels];
  logic [TimerBits-1:0] period_m     [NumChannels];
  logic [StampBits-1:0] edge_stamp_m [NumChannels];
  logic                 chan_live_m  [NumChannels];
  logic [FreqBits-1:0]  held_freq_m  = '0;
  logic                 held_valid_m = 1'b0;

  // Stimulus generator state, tracking what each channel last saw.
  logic [TimerBits-1:0] gen_cap  [NumChannels];
  logic [StampBits-1:0] gen_edge [NumChannels];
  logic [StampBits-1:0] gen_stamp = '0;

  int unsigned queued_items   = 0;
  int unsigned accepted_items = 0;
  int unsigned mismatches     = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_left      = 0;
  int unsigned holds_served   = 0;
  int unsigned holds_wanted   = 0;
  int unsigned quiet_cycles   = 0;

  capture_frequency_meter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .channel_i      (channel_i),
    .capture_value_i(capture_value_i),
    .now_stamp_i    (now_stamp_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frequency_o    (frequency_o),
    .valid_res_o    (valid_res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    for (int k = 0; k < NumChannels; k++) begin
      last_cap_m[k]   = '0;
      period_m[k]     = '0;
      edge_stamp_m[k] = '0;
      chan_live_m[k]  = 1'b0;
      gen_cap[k]      = '0;
      gen_edge[k]     = '0;
    end
  end

  task automatic predict_meter(input meter_item_t it);
    logic [StampBits-1:0] age;
    if (it.mode == ModeCapture) begin
      period_m[it.channel]     = it.capture - last_cap_m[it.channel];
      last_cap_m[it.channel]   = it.capture;
      edge_stamp_m[it.channel] = it.stamp;
      chan_live_m[it.channel]  = 1'b1;
    end else begin
      age = it.stamp - edge_stamp_m[it.channel];
      if (age < timeout_m) begin
        if (period_m[it.channel] != '0 && chan_live_m[it.channel]) begin
          held_freq_m  = FreqBits'(ref_hz_m / period_m[it.channel]);
          held_valid_m = 1'b1;
        end
      end else begin
        chan_live_m[it.channel] = 1'b0;
        held_valid_m            = 1'b0;
      end
      reading_q.push_back('{freq: held_freq_m, valid: held_valid_m});
    end
  endtask

  task automatic queue_item(input logic mode, input logic [ChanBits-1:0] ch,
                            input logic [TimerBits-1:0] cap, input logic [StampBits-1:0] stamp);
    if (mode == ModeCapture) begin
      gen_cap[ch]  = cap;
      gen_edge[ch] = stamp;
    end
    pending_items_q.push_back('{mode: mode, channel: ch, capture: cap, stamp: stamp});
    queued_items++;
  endtask

  task automatic program_meter(input logic [CfgBits-1:0] ref_val,
                               input logic [CfgBits-1:0] tmo_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgRefClock;
    cfg_data_i  <= ref_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    ref_hz_m = ref_val;
    cfg_index_i <= CfgTimeout;
    cfg_data_i  <= tmo_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    timeout_m = tmo_val;
    cfg_valid_i <= 1'b0;
  endtask

  // Captures give no reading, so the wait also counts accepted items before the final drain.
  task automatic wait_drained();
    while (accepted_items != queued_items || reading_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_items
    meter_item_t offer;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_meter('{mode: mode_i, channel: channel_i, capture: capture_value_i,
                        stamp: now_stamp_i});
        accepted_items++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          offer = pending_items_q.pop_front();
          mode_i          <= offer.mode;
          channel_i       <= offer.channel;
          capture_value_i <= offer.capture;
          now_stamp_i     <= offer.stamp;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_readings
    meter_reading_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (reading_q.size() == 0) begin
          if (mismatches < MaxReports) begin
            $display("%0t: reading with none expected: frequency %0d valid %0b",
                     $realtime, frequency_o, valid_res_o);
          end
          mismatches++;
        end else begin
          want = reading_q.pop_front();
          if (frequency_o !== want.freq || valid_res_o !== want.valid) begin
            if (mismatches < MaxReports) begin
              $display("%0t: frequency expected %0d got %0d, valid expected %0b got %0b",
                       $realtime, want.freq, frequency_o, want.valid, valid_res_o);
            end
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (holds_served < holds_wanted) begin
        hold_left = LongHold - 1;
        holds_served++;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $realtime, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : run_phases
    logic [CfgBits-1:0]   ref_val;
    logic [CfgBits-1:0]   tmo_val;
    logic [StampBits-1:0] fresh_span;
    logic [StampBits-1:0] age;
    logic [TimerBits-1:0] step;
    logic [ChanBits-1:0]  ch;
    int unsigned          item_count;
    int unsigned          pick;
    int unsigned          sel;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: wrap of period and stamp, zero period, timeout boundary.
    queue_item(ModeQuery,   1'b0, 16'h0000, 24'd5);
    queue_item(ModeQuery,   1'b1, 16'hFFFF, 24'hFFFFFF);
    queue_item(ModeCapture, 1'b0, 16'd100,  24'd10);
    queue_item(ModeCapture, 1'b0, 16'd600,  24'd20);
    queue_item(ModeQuery,   1'b0, 16'h0000, 24'd30);
    queue_item(ModeCapture, 1'b1, 16'hFFFF, 24'd40);
    queue_item(ModeCapture, 1'b1, 16'h0000, 24'd50);
    queue_item(ModeQuery,   1'b1, 16'h0000, 24'd60);
    queue_item(ModeCapture, 1'b1, 16'h0000, 24'd70);
    queue_item(ModeQuery,   1'b1, 16'h0000, 24'd80);
    queue_item(ModeQuery,   1'b0, 16'h0000, 24'd10500020);
    queue_item(ModeQuery,   1'b0, 16'h0000, 24'd25);
    queue_item(ModeCapture, 1'b0, 16'd1000, 24'hFFFFF0);
    queue_item(ModeCapture, 1'b0, 16'd999,  24'hFFFFFA);
    queue_item(ModeQuery,   1'b0, 16'hFFFF, 24'd5);
    queue_item(ModeQuery,   1'b1, 16'h0000, 24'd10500069);
    wait_drained();

    for (int phase = 1; phase < NumPhases; phase++) begin
      item_count = 150;
      case (phase)
        1: begin ref_val = '1; tmo_val = '1; end
        2: begin ref_val = 24'd1; tmo_val = 24'd1; end
        3: begin ref_val = 24'd1000000; tmo_val = 24'd5000; end
        4: begin ref_val = CfgBits'($urandom); tmo_val = CfgBits'($urandom); end
        5: begin ref_val = '0; tmo_val = '1; item_count = 60; end
        6: begin ref_val = CfgBits'($urandom); tmo_val = '0; item_count = 60; end
        7: begin ref_val = CfgBits'($urandom); tmo_val = CfgBits'($urandom_range(200000, 1000)); end
        8: begin ref_val = CfgBits'($urandom); tmo_val = CfgBits'($urandom); end
        default: begin ref_val = 24'd12345678; tmo_val = 24'd100000; end
      endcase
      program_meter(ref_val, tmo_val);
      case (phase)
        2, 5:    begin sender_idle_pct = 54; recv_stall_pct = 0;  end
        3, 6, 8: begin sender_idle_pct = 0;  recv_stall_pct = 54; end
        4, 9:    begin sender_idle_pct = 13; recv_stall_pct = 13; end
        default: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase

      fresh_span = (timeout_m == '0) ? '0 : timeout_m - 1'b1;
      for (int n = 0; n < item_count; n++) begin
        ch   = ChanBits'($urandom_range(NumChannels - 1, 0));
        pick = $urandom_range(99, 0);
        if (pick < 45) begin
          sel = $urandom_range(99, 0);
          if (sel < 80) step = TimerBits'($urandom_range(2000, 1));
          else if (sel < 90) step = TimerBits'($urandom_range(65535, 2001));
          else if (sel < 95) step = '0;
          else step = TimerBits'($urandom);
          gen_stamp = gen_stamp + StampBits'($urandom_range(timeout_m / 4 + 1, 1));
          queue_item(ModeCapture, ch, gen_cap[ch] + step, gen_stamp);
        end else if (pick < 85) begin
          if ($urandom_range(99, 0) < 80 || timeout_m == '0) begin
            age = StampBits'($urandom_range(fresh_span, 0));
          end else begin
            age = StampBits'($urandom_range(24'hFFFFFF, timeout_m));
          end
          gen_stamp = gen_edge[ch] + age;
          queue_item(ModeQuery, ch, TimerBits'($urandom), gen_stamp);
        end else begin
          queue_item(1'($urandom), ch, TimerBits'($urandom), StampBits'($urandom));
        end
      end
      if (phase == PressurePhase) begin
        holds_wanted++;
      end
      wait_drained();
    end

    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
